// File: sv/e2c_pkg.sv
`default_nettype none

package e2c_pkg;

  // Sequencer program counter
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Program addresses that are jump targets
  localparam pc_t PC_WAIT  = 4'd0;
  localparam pc_t PC_YEAR  = 4'd9;
  localparam pc_t PC_MONTH = 4'd11;

  typedef enum logic [3:0] {
    OP_WAIT,    // take an input beat
    OP_DAY,     // days = seconds / 86400
    OP_SOD,     // second of day; days+4 kept for the weekday
    OP_HOUR,    // hour = second of day / 3600
    OP_SOH,     // second of hour
    OP_MIN,     // minute = second of hour / 60
    OP_SEC,     // second = what is left of the minute
    OP_WEEK,    // weeks in days+4, low bits only
    OP_WDAY,    // keep weekday, start year walk
    OP_YEAR,    // subtract one year length
    OP_YDONE,   // keep day of year, start month walk
    OP_MONTH,   // subtract one month length
    OP_EMIT     // load result register
  } op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_YEAR_MORE,
    COND_MON_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic stall;
    logic year_more;
    logic mon_more;
  } dp_stat_t;

  localparam logic [7:0]  YOFF_EPOCH = 8'd70;   // 1970 - 1900
  localparam logic [7:0]  YOFF_2100  = 8'd200;  // century year, not leap
  localparam logic [15:0] WDAY_EPOCH = 16'd4;   // 1970-01-01 was a Thursday
  localparam logic [8:0]  YEAR_NORM  = 9'd365;
  localparam logic [8:0]  YEAR_LEAP  = 9'd366;
  localparam logic [3:0]  MON_FEB    = 4'd1;
  localparam logic [3:0]  MON_DEC    = 4'd11;

  localparam logic [16:0] SECS_DAY  = 17'd86400;
  localparam logic [11:0] SECS_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_MIN  = 6'd60;
  localparam logic [2:0]  DAYS_WEEK = 3'd7;

  // Reciprocals, exact floor division over each operand's range:
  //   days   = ((t >> 7) * M_DAY) >> 35       (86400 = 128 * 675, t >> 7 < 2^25)
  //   hour   = ((sod >> 4) * M_HOUR) >> 21    (3600 = 16 * 225, sod >> 4 < 2^13)
  //   minute = ((soh >> 2) * M_MIN) >> 14     (60 = 4 * 15, soh >> 2 < 2^10)
  //   weeks  = (x * M_WEEK) >> 19             (x = days + 4 < 2^16)
  localparam logic [25:0] M_DAY  = 26'd50903317;
  localparam logic [13:0] M_HOUR = 14'd9321;
  localparam logic [10:0] M_MIN  = 11'd1093;
  localparam logic [16:0] M_WEEK = 17'd74899;

  // Offsets 70..206 only: 2000 is the sole multiple of 400, 2100 the sole other century
  function automatic logic leap_year(input logic [7:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != YOFF_2100);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      MON_FEB:                   len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Microcode ROM
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_WAIT,  COND_NONE,      PC_WAIT};
      4'd1:    w = '{OP_DAY,   COND_NONE,      PC_WAIT};
      4'd2:    w = '{OP_SOD,   COND_NONE,      PC_WAIT};
      4'd3:    w = '{OP_HOUR,  COND_NONE,      PC_WAIT};
      4'd4:    w = '{OP_SOH,   COND_NONE,      PC_WAIT};
      4'd5:    w = '{OP_MIN,   COND_NONE,      PC_WAIT};
      4'd6:    w = '{OP_SEC,   COND_NONE,      PC_WAIT};
      4'd7:    w = '{OP_WEEK,  COND_NONE,      PC_WAIT};
      4'd8:    w = '{OP_WDAY,  COND_NONE,      PC_WAIT};
      4'd9:    w = '{OP_YEAR,  COND_YEAR_MORE, PC_YEAR};
      4'd10:   w = '{OP_YDONE, COND_NONE,      PC_WAIT};
      4'd11:   w = '{OP_MONTH, COND_MON_MORE,  PC_MONTH};
      4'd12:   w = '{OP_EMIT,  COND_ALWAYS,    PC_WAIT};
      default: w = '{OP_WAIT,  COND_ALWAYS,    PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/e2c_ifs.sv
`default_nettype none

interface e2c_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [7:0] year_offset;
  logic [8:0] day_of_year;
  logic [3:0] month;
  logic [4:0] day_of_month;

  modport source (output valid, output second, output minute, output hour,
                  output weekday, output year_offset, output day_of_year,
                  output month, output day_of_month, input ready);
  modport sink   (input valid, input second, input minute, input hour,
                  input weekday, input year_offset, input day_of_year,
                  input month, input day_of_month, output ready);
endinterface

`default_nettype wire

// File: sv/e2c_seq.sv
`default_nettype none

module e2c_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire e2c_pkg::dp_stat_t  stat_i,
  output e2c_pkg::uword_t         uw_o
);

  e2c_pkg::pc_t    pc_q, pc_d;
  e2c_pkg::uword_t uw;
  logic            jump;

  assign uw   = e2c_pkg::ucode(pc_q);
  assign uw_o = uw;

  always_comb begin
    unique case (uw.cond)
      e2c_pkg::COND_NONE:      jump = 1'b0;
      e2c_pkg::COND_ALWAYS:    jump = 1'b1;
      e2c_pkg::COND_YEAR_MORE: jump = stat_i.year_more;
      e2c_pkg::COND_MON_MORE:  jump = stat_i.mon_more;
      default:                 jump = 1'b0;
    endcase
  end

  always_comb begin
    priority if (stat_i.stall) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + e2c_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= e2c_pkg::PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/e2c_dp.sv
`default_nettype none

module e2c_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire e2c_pkg::uword_t   uw_i,
  output e2c_pkg::dp_stat_t      stat_o,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [31:0]       epoch_seconds_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [5:0]             second_o,
  output logic [5:0]             minute_o,
  output logic [4:0]             hour_o,
  output logic [2:0]             weekday_o,
  output logic [7:0]             year_offset_o,
  output logic [8:0]             day_of_year_o,
  output logic [3:0]             month_o,
  output logic [4:0]             day_of_month_o
);

  // working registers
  logic [31:0] n_q, n_d;
  logic [16:0] r_q, r_d;
  logic [15:0] days_q, days_d;
  logic [5:0]  sec_q, sec_d, min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [2:0]  wq_q, wq_d;
  logic [2:0]  wd_q, wd_d;
  logic [7:0]  yoff_q, yoff_d;
  logic [8:0]  yday_q, yday_d;
  logic [3:0]  mon_q, mon_d;

  // result register
  logic        ovld_q, ovld_d;
  logic [5:0]  osec_q, omin_q;
  logic [4:0]  ohour_q, odom_q;
  logic [2:0]  owd_q;
  logic [7:0]  oyoff_q;
  logic [8:0]  oyday_q;
  logic [3:0]  omon_q;

  // reciprocal quotients and remainders; remainders are exact in their width
  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [21:0] week_prod;
  logic [16:0] day_back, sod;
  logic [11:0] hour_back, soh;
  logic [5:0]  min_back;
  logic [2:0]  wk_back;

  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        year_more, mon_more;
  logic        is_wait, is_emit, stall, emit;

  assign day_prod  = {26'b0, n_q[31:7]} * {25'b0, e2c_pkg::M_DAY};
  assign day_back  = {1'b0, days_q} * e2c_pkg::SECS_DAY;
  assign sod       = n_q[16:0] - day_back;
  assign hour_prod = {14'b0, r_q[16:4]} * {13'b0, e2c_pkg::M_HOUR};
  assign hour_back = {7'b0, hour_q} * e2c_pkg::SECS_HOUR;
  assign soh       = r_q[11:0] - hour_back;
  assign min_prod  = {11'b0, r_q[11:2]} * {10'b0, e2c_pkg::M_MIN};
  assign min_back  = min_q * e2c_pkg::SECS_MIN;
  // only weeks mod 8 matter for the 3-bit remainder
  assign week_prod = {6'b0, n_q[15:0]} * {5'b0, e2c_pkg::M_WEEK};
  assign wk_back   = wq_q * e2c_pkg::DAYS_WEEK;

  assign leap      = e2c_pkg::leap_year(yoff_q);
  assign ylen      = leap ? e2c_pkg::YEAR_LEAP : e2c_pkg::YEAR_NORM;
  assign year_more = days_q >= {7'b0, ylen};
  assign mlen      = e2c_pkg::month_days(mon_q, leap);
  assign mon_more  = (mon_q != e2c_pkg::MON_DEC) && (days_q >= {11'b0, mlen});

  assign is_wait = (uw_i.op == e2c_pkg::OP_WAIT);
  assign is_emit = (uw_i.op == e2c_pkg::OP_EMIT);
  assign stall   = (is_wait && !in_valid_i) || (is_emit && ovld_q && !out_ready_i);
  assign emit    = is_emit && !stall;

  assign stat_o.stall     = stall;
  assign stat_o.year_more = year_more;
  assign stat_o.mon_more  = mon_more;

  always_comb begin
    n_d    = n_q;
    r_d    = r_q;
    days_d = days_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    wq_d   = wq_q;
    wd_d   = wd_q;
    yoff_d = yoff_q;
    yday_d = yday_q;
    mon_d  = mon_q;
    unique case (uw_i.op)
      e2c_pkg::OP_WAIT: begin
        if (in_valid_i) begin
          n_d = epoch_seconds_i;
        end
      end
      e2c_pkg::OP_DAY: begin
        days_d = day_prod[50:35];
      end
      e2c_pkg::OP_SOD: begin
        r_d = sod;
        n_d = {16'b0, days_q + e2c_pkg::WDAY_EPOCH};
      end
      e2c_pkg::OP_HOUR: begin
        hour_d = hour_prod[25:21];
      end
      e2c_pkg::OP_SOH: begin
        r_d = {5'b0, soh};
      end
      e2c_pkg::OP_MIN: begin
        min_d = min_prod[19:14];
      end
      e2c_pkg::OP_SEC: begin
        sec_d = r_q[5:0] - min_back;
      end
      e2c_pkg::OP_WEEK: begin
        wq_d = week_prod[21:19];
      end
      e2c_pkg::OP_WDAY: begin
        wd_d   = n_q[2:0] - wk_back;
        yoff_d = e2c_pkg::YOFF_EPOCH;
      end
      e2c_pkg::OP_YEAR: begin
        if (year_more) begin
          days_d = days_q - {7'b0, ylen};
          yoff_d = yoff_q + 8'd1;
        end
      end
      e2c_pkg::OP_YDONE: begin
        yday_d = days_q[8:0];
        mon_d  = '0;
      end
      e2c_pkg::OP_MONTH: begin
        if (mon_more) begin
          days_d = days_q - {11'b0, mlen};
          mon_d  = mon_q + 4'd1;
        end
      end
      e2c_pkg::OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    priority if (emit) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    r_q    <= r_d;
    days_q <= days_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    wq_q   <= wq_d;
    wd_q   <= wd_d;
    yoff_q <= yoff_d;
    yday_q <= yday_d;
    mon_q  <= mon_d;
    if (emit) begin
      osec_q  <= sec_q;
      omin_q  <= min_q;
      ohour_q <= hour_q;
      owd_q   <= wd_q;
      oyoff_q <= yoff_q;
      oyday_q <= yday_q;
      omon_q  <= mon_q;
      odom_q  <= days_q[4:0] + 5'd1;
    end
  end

  assign in_ready_o     = is_wait;
  assign out_valid_o    = ovld_q;
  assign second_o       = osec_q;
  assign minute_o       = omin_q;
  assign hour_o         = ohour_q;
  assign weekday_o      = owd_q;
  assign year_offset_o  = oyoff_q;
  assign day_of_year_o  = oyday_q;
  assign month_o        = omon_q;
  assign day_of_month_o = odom_q;

endmodule

`default_nettype wire

// File: sv/epoch_seconds_to_calendar_unit.sv
// Conversion time: the year step repeats once per year past 1970 and the month step
//   once per month past January, so it grows with the date.
// One item at a time: the next input beat is taken in the cycle after the result
//   register loads.
// Emit holds while the output register is full and not taken; the input then waits.
// Reset (rst_ni low, asynchronous): sequencer returns to the wait step, output empty.
`default_nettype none

module epoch_seconds_to_calendar_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  e2c_req_if.sink   req_i,
  e2c_rsp_if.source rsp_o
);

  // Program, one control word per step:
  //   wait     take input beat
  //   day      days by reciprocal multiply of seconds >> 7
  //   sod      second of day = seconds - days * 86400; days+4 kept for weekday
  //   hour     hour by reciprocal multiply of sod >> 4
  //   soh      second of hour = sod - hour * 3600
  //   min      minute by reciprocal multiply of soh >> 2
  //   sec      second = soh - minute * 60
  //   week     weeks in days+4, low three bits
  //   wday     weekday = days+4 - weeks * 7; year walk starts at 1970
  //   year     loop: subtract 365/366 while days allow
  //   ydone    day of year kept; month walk starts at January
  //   month    loop: subtract month length, stops at December
  //   emit     load result register, back to wait (holds while it is full and not taken)

  e2c_pkg::uword_t   uw;
  e2c_pkg::dp_stat_t stat;

  e2c_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uw_o   (uw)
  );

  e2c_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .uw_i            (uw),
    .stat_o          (stat),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .epoch_seconds_i (req_i.epoch_seconds),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .second_o        (rsp_o.second),
    .minute_o        (rsp_o.minute),
    .hour_o          (rsp_o.hour),
    .weekday_o       (rsp_o.weekday),
    .year_offset_o   (rsp_o.year_offset),
    .day_of_year_o   (rsp_o.day_of_year),
    .month_o         (rsp_o.month),
    .day_of_month_o  (rsp_o.day_of_month)
  );

endmodule

`default_nettype wire

// File: tb/calendar_checker.sv
`timescale 1ns / 100ps

module calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  e2c_req_if          req_i,
  e2c_rsp_if          rsp_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year_offset;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } calendar_t;

  calendar_t   calendar_expect_q[$];
  calendar_t   predicted;
  calendar_t   observed;
  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic bit gregorian_leap(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned mon, input int unsigned year);
    if (mon == 1)
      return gregorian_leap(year) ? 29 : 28;
    if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
      return 30;
    return 31;
  endfunction

  // Year walk from 1970, then month walk; December takes whatever is left
  function automatic calendar_t to_calendar(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned t;
    int unsigned days;
    int unsigned year;
    int unsigned year_len;
    int unsigned mon;
    t                = secs;
    days             = t / 86400;
    cal.second       = 6'(t % 60);
    cal.minute       = 6'((t / 60) % 60);
    cal.hour         = 5'((t / 3600) % 24);
    cal.weekday      = 3'((days + 4) % 7);
    year             = 1970;
    year_len         = gregorian_leap(year) ? 366 : 365;
    while (days >= year_len) begin
      days     = days - year_len;
      year     = year + 1;
      year_len = gregorian_leap(year) ? 366 : 365;
    end
    cal.year_offset  = 8'(year - 1900);
    cal.day_of_year  = 9'(days);
    mon              = 0;
    while (mon < 11 && days >= month_length(mon, year)) begin
      days = days - month_length(mon, year);
      mon  = mon + 1;
    end
    cal.month        = 4'(mon);
    cal.day_of_month = 5'(days + 1);
    return cal;
  endfunction

  function automatic string cal_str(input calendar_t c);
    return $sformatf("yoff %0d mon %0d mday %0d yday %0d wday %0d %0d:%0d:%0d",
                     c.year_offset, c.month, c.day_of_month, c.day_of_year,
                     c.weekday, c.hour, c.minute, c.second);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_i.valid && req_i.ready)
        calendar_expect_q.push_back(to_calendar(req_i.epoch_seconds));
      if (rsp_i.valid && rsp_i.ready) begin
        observed = '{rsp_i.second, rsp_i.minute, rsp_i.hour, rsp_i.weekday,
                     rsp_i.year_offset, rsp_i.day_of_year, rsp_i.month,
                     rsp_i.day_of_month};
        if (calendar_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t chk: result beat with nothing outstanding: %s",
                     $time, cal_str(observed));
        end else begin
          predicted = calendar_expect_q.pop_front();
          checked_count++;
          if (observed !== predicted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t chk: mismatch\n  exp %s\n  got %s",
                       $time, cal_str(predicted), cal_str(observed));
          end
        end
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= calendar_expect_q.size();
    checked_o    <= checked_count;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned STALL_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int unsigned HOLD_CYCLES  = 400;   // long result back-pressure, > worst latency
  localparam int unsigned DRAIN_CYCLES = 250;   // more than the worst latency

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_rsp;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned i;

  e2c_req_if req_if();
  e2c_rsp_if rsp_if();

  epoch_seconds_to_calendar_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Watches both channels, predicts each conversion and compares
  calendar_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Seconds at a given day of a given year, plus an offset that may run
  // either side of midnight. The leap count is exact up to 2100 only; past
  // that it lands a day late, which is harmless for stimulus.
  function automatic logic [31:0] at_day(input int year, input int doy, input int offset);
    longint days;
    days = longint'(year - 1970) * 365 + longint'((year - 1969) / 4) + doy;
    return 32'(days * 86400 + offset);
  endfunction

  // Weighted towards the awkward corners: new year, end of February,
  // month ends and the top of the 32-bit range
  function automatic logic [31:0] random_epoch();
    int unsigned pick;
    int          year;
    pick = $urandom_range(0, 99);
    year = $urandom_range(1970, 2106);
    if (pick < 40)
      return $urandom;
    if (pick < 60)
      return at_day(year, 0, int'($urandom_range(0, 7200)) - 3600);
    if (pick < 75)
      return at_day(year, $urandom_range(57, 60), $urandom_range(0, 86399));
    if (pick < 88)
      return at_day(year, $urandom_range(0, 365), $urandom_range(0, 1) ? 86399 : 0);
    if (pick < 95)
      return $urandom_range(0, 32'h000F_FFFF);
    return 32'hFFFF_FFFF - $urandom_range(0, 200000);
  endfunction

  // Entered and left at a falling edge. Valid is only lowered for an idle
  // cycle, so a back-to-back beat never sees two assignments in one step.
  task automatic send_beat(input logic [31:0] secs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.epoch_seconds <= secs;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: random back-pressure, or one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.epoch_seconds = '0;
    hold_rsp             = 1'b0;
    stall_cycles         = 0;
    send_idle_pct        = 21;
    recv_idle_pct        = 68;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field wrap points, leap days, century rule, range ends
    send_beat(32'd0);
    send_beat(32'd59);
    send_beat(32'd60);
    send_beat(32'd3599);
    send_beat(32'd3600);
    send_beat(32'd86399);
    send_beat(32'd86400);
    send_beat(at_day(1970, 364, 86399));   // last second of the first year
    send_beat(at_day(1972, 59, 0));        // first leap day
    send_beat(at_day(1972, 365, 86399));   // day 366 of a leap year
    send_beat(at_day(2000, 59, 43200));    // leap day in a 400-year
    send_beat(at_day(2000, 60, 0));
    send_beat(at_day(2000, 365, 86399));
    send_beat(at_day(2100, 58, 86399));    // century year, no leap day
    send_beat(at_day(2100, 59, 0));
    send_beat(at_day(2100, 364, 86399));
    send_beat(32'h7FFF_FFFF);
    send_beat(32'h8000_0000);
    send_beat(32'h5555_5555);
    send_beat(32'hAAAA_AAAA);
    send_beat(32'hFFFF_FFFF);              // top of range, February 2106

    // Random: sender-light/receiver-heavy idling, then swapped, then none.
    // The hold-off in the last third fills the block so its input stalls.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 21;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 2 * RANDOM_ITEMS / 3 + 20)
        hold_rsp = 1'b1;
      send_beat(random_epoch());
    end
    req_if.valid <= 1'b0;

    // Let the last conversions drain, then leave room for strays
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d conversions checked over skewed idling both ways, a free-running",
             checked);
    $display("tb: stretch and a long result hold-off; %0d mismatch(es)", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/e2c_pkg.sv
sv/e2c_ifs.sv
sv/e2c_seq.sv
sv/e2c_dp.sv
sv/epoch_seconds_to_calendar_unit.sv
tb/calendar_checker.sv
tb/tb.sv
